@@ design/btcs_pkg.sv @@
// Shared types and constants for the triangle coverage and shading pipeline.
`default_nettype none

package btcs_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_VERTEX_A_POS = 3'd0,
        REG_VERTEX_B_POS = 3'd1,
        REG_VERTEX_C_POS = 3'd2,
        REG_COLOR_A      = 3'd3,
        REG_COLOR_B      = 3'd4,
        REG_COLOR_C      = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int HALF_BITS = 16;
    localparam int CH_BITS = 8;
    localparam int NUM_CH = 3;
    localparam int NUM_VERT = 3;
    localparam int QUOT_BITS = CH_BITS;
    localparam logic [CH_BITS-1:0] ALPHA_FULL = 8'hFF;

endpackage

`default_nettype wire

@@ design/btcs_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, quotient known to fit in 8 bits.
`default_nettype none

module btcs_div
    import btcs_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 39
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]     i_den,
    output logic      [QUOT_BITS-1:0] o_quot
);

    localparam int CMP_W = ((NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS) + 1;

    logic [NUM_W-1:0]     r_rem [QUOT_BITS-1];
    logic [DEN_W-1:0]     r_den [QUOT_BITS-1];
    logic [QUOT_BITS-1:0] r_quot [QUOT_BITS];

    for (genvar gi = 0; gi < QUOT_BITS; gi++) begin : g_step
        localparam int SH = QUOT_BITS - 1 - gi;

        logic [NUM_W-1:0]     rem_in;
        logic [DEN_W-1:0]     den_in;
        logic [QUOT_BITS-1:0] quot_in;
        logic [CMP_W-1:0]     shifted;
        logic                 ge;
        logic [NUM_W-1:0]     n_rem;
        logic [QUOT_BITS-1:0] n_quot;

        if (gi == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[gi-1];
            assign den_in  = r_den[gi-1];
            assign quot_in = r_quot[gi-1];
        end

        always_comb begin
            shifted = CMP_W'(den_in) << SH;
            ge      = CMP_W'(rem_in) >= shifted;
            n_rem   = ge ? NUM_W'(CMP_W'(rem_in) - shifted) : rem_in;
            n_quot  = quot_in;
            n_quot[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[gi] <= n_quot;
            end
        end

        if (gi < QUOT_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gi] <= n_rem;
                    r_den[gi] <= den_in;
                end
            end
        end else begin : g_last
            // The final remainder is not needed.
            logic unused_rem;
            assign unused_rem = ^n_rem;
        end
    end

    assign o_quot = r_quot[QUOT_BITS-1];

endmodule

`default_nettype wire

@@ design/barycentric_triangle_color_shade_unit.sv @@
// Throughput: one pixel per cycle; the whole pipeline holds when the output is stalled.
// The depth is set by the eight-stage divider that forms each colour channel.
// Synchronous active-low reset clears all vertex and colour registers and every stage
// valid bit; pipeline data registers are not reset.
`default_nettype none

module barycentric_triangle_color_shade_unit
    import btcs_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [PIXEL_BITS-1:0]    i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0]    i_pixel_y,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_covered,
    output logic      [PIXEL_BITS-1:0]    o_out_x,
    output logic      [PIXEL_BITS-1:0]    o_out_y,
    output logic      [31:0]              o_pixel_color
);

    localparam int CW = (COORD_BITS < HALF_BITS) ? COORD_BITS : HALF_BITS;
    localparam int DW = ((CW > PIXEL_BITS) ? CW : PIXEL_BITS + 1) + 1;
    localparam int PW = 2 * DW;
    localparam int WW = PW + 1;
    localparam int SW = WW + 2;
    localparam int AW = WW + 1;
    localparam int MW = AW + CH_BITS;
    localparam int NW = MW + 2;
    localparam int NS = 6 + QUOT_BITS;

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0] r_pos [NUM_VERT];
    logic [CFG_DATA_BITS-1:0] r_col [NUM_VERT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VERT; v++) begin
                r_pos[v] <= '0;
                r_col[v] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_VERTEX_A_POS: r_pos[0] <= i_cfg_data;
                REG_VERTEX_B_POS: r_pos[1] <= i_cfg_data;
                REG_VERTEX_C_POS: r_pos[2] <= i_cfg_data;
                REG_COLOR_A:      r_col[0] <= i_cfg_data;
                REG_COLOR_B:      r_col[1] <= i_cfg_data;
                REG_COLOR_C:      r_col[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall control and valid bits.
    logic          en;
    logic          r_vld [NS];
    logic [PIXEL_BITS-1:0] r_px [NS];
    logic [PIXEL_BITS-1:0] r_py [NS];
    logic          r_cov [NS-3];

    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= i_pixel_x;
            r_py[0] <= i_pixel_y;
            for (int s = 1; s < NS; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
            end
        end
    end

    // Stage 0: vertex minus pixel differences.
    logic signed [DW-1:0] n_dx [NUM_VERT];
    logic signed [DW-1:0] n_dy [NUM_VERT];
    logic signed [DW-1:0] r_dx [NUM_VERT];
    logic signed [DW-1:0] r_dy [NUM_VERT];

    always_comb begin
        for (int v = 0; v < NUM_VERT; v++) begin
            n_dx[v] = {{(DW-CW){r_pos[v][CW-1]}}, r_pos[v][CW-1:0]}
                    - {{(DW-PIXEL_BITS){1'b0}}, i_pixel_x};
            n_dy[v] = {{(DW-CW){r_pos[v][HALF_BITS+CW-1]}}, r_pos[v][HALF_BITS+CW-1:HALF_BITS]}
                    - {{(DW-PIXEL_BITS){1'b0}}, i_pixel_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Stage 1: the six cross products. Edge opposite vertex v uses vertices v+1 and v+2.
    logic signed [PW-1:0] r_pl [NUM_VERT];
    logic signed [PW-1:0] r_pr [NUM_VERT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl[0] <= r_dx[1] * r_dy[2];
            r_pr[0] <= r_dx[2] * r_dy[1];
            r_pl[1] <= r_dx[2] * r_dy[0];
            r_pr[1] <= r_dx[0] * r_dy[2];
            r_pl[2] <= r_dx[0] * r_dy[1];
            r_pr[2] <= r_dx[1] * r_dy[0];
        end
    end

    // Stage 2: edge functions.
    logic signed [WW-1:0] r_w [NUM_VERT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < NUM_VERT; v++) begin
                r_w[v] <= {r_pl[v][PW-1], r_pl[v]} - {r_pr[v][PW-1], r_pr[v]};
            end
        end
    end

    // Stage 3: the edge functions sum to the doubled area; fold the winding to positive.
    logic signed [SW-1:0] area;
    logic                 neg;
    logic signed [AW-1:0] n_aw [NUM_VERT];
    logic                 n_cov;
    logic [AW-1:0]        r_aw [NUM_VERT];
    logic [SW-1:0]        r_den [3];

    always_comb begin
        area  = SW'(r_w[0]) + SW'(r_w[1]) + SW'(r_w[2]);
        neg   = area[SW-1];
        n_cov = (area != '0);
        for (int v = 0; v < NUM_VERT; v++) begin
            n_aw[v] = neg ? -AW'(r_w[v]) : AW'(r_w[v]);
            n_cov   = n_cov && !n_aw[v][AW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < NUM_VERT; v++) begin
                r_aw[v] <= n_aw[v];
            end
            r_den[0] <= neg ? -area : area;
            r_den[1] <= r_den[0];
            r_den[2] <= r_den[1];
            r_cov[0] <= n_cov;
            for (int s = 1; s < NS - 3; s++) begin
                r_cov[s] <= r_cov[s-1];
            end
        end
    end

    // Stage 4: weight times channel products.
    logic [MW-1:0] r_prod [NUM_CH][NUM_VERT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                for (int v = 0; v < NUM_VERT; v++) begin
                    r_prod[c][v] <= MW'(r_aw[v])
                                  * MW'(r_col[v][(NUM_CH-1-c)*CH_BITS +: CH_BITS]);
                end
            end
        end
    end

    // Stage 5: numerators, forced to zero for pixels outside the triangle.
    logic [NW-1:0] r_num [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_num[c] <= r_cov[1]
                          ? NW'(r_prod[c][0]) + NW'(r_prod[c][1]) + NW'(r_prod[c][2])
                          : '0;
            end
        end
    end

    // Stages 6 and on: one divider per channel. Weights sum to the area, so quotients
    // never exceed 255.
    logic [QUOT_BITS-1:0] quot [NUM_CH];

    for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_ch
        btcs_div #(
            .NUM_W (NW),
            .DEN_W (SW)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[gc]),
            .i_den  (r_den[2]),
            .o_quot (quot[gc])
        );
    end

    assign o_valid       = r_vld[NS-1];
    assign o_covered     = r_cov[NS-4];
    assign o_out_x       = r_px[NS-1];
    assign o_out_y       = r_py[NS-1];
    assign o_pixel_color = r_cov[NS-4] ? {ALPHA_FULL, quot[0], quot[1], quot[2]} : '0;

endmodule

`default_nettype wire

@@ design/btcs_checker.sv @@
// Port-level checker for the triangle shading unit, bound to the top level.
`default_nettype none

module btcs_checker #(
    parameter int PIXEL_BITS = 12
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_ready,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic                  o_covered,
    input wire logic [PIXEL_BITS-1:0] o_out_x,
    input wire logic [PIXEL_BITS-1:0] o_out_y,
    input wire logic [31:0]           o_pixel_color
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_color) && $stable(o_out_x)
                                && $stable(o_out_y) && $stable(o_covered))
        else $error("output changed while stalled");

    // An empty output stage never holds back the input.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_covered |-> o_pixel_color == 32'h0)
        else $error("uncovered pixel has nonzero colour");

    a_covered_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_covered |-> o_pixel_color[31:24] == 8'hFF)
        else $error("covered pixel lacks full alpha");

endmodule

bind barycentric_triangle_color_shade_unit btcs_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_btcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_covered     (o_covered),
    .o_out_x       (o_out_x),
    .o_out_y       (o_out_y),
    .o_pixel_color (o_pixel_color)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the triangle coverage and Gouraud shading unit.
`timescale 1ns / 1ps

module testbench;
    import btcs_pkg::*;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } t_pixel;

    typedef struct {
        logic        covered;
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] color;
    } t_shade;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [11:0] i_pixel_x;
    logic [11:0] i_pixel_y;
    logic        o_valid;
    logic        i_ready;
    logic        o_covered;
    logic [11:0] o_out_x;
    logic [11:0] o_out_y;
    logic [31:0] o_pixel_color;

    barycentric_triangle_color_shade_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_covered(o_covered), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_pixel_color(o_pixel_color)
    );

    logic [31:0] tri_regs [0:5];
    t_pixel      pixels_to_send [$];
    t_shade      shades_due [$];
    bit          calm;
    int          errors;
    int          quiet_cycles;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint signed coord(logic [15:0] half);
        return longint'($signed(half));
    endfunction

    function automatic logic [7:0] blend(longint signed wa, longint signed wb,
                                         longint signed wc, longint signed area,
                                         int sh);
        longint signed num;
        longint signed q;
        num = wa * longint'((tri_regs[REG_COLOR_A] >> sh) & 32'hFF)
            + wb * longint'((tri_regs[REG_COLOR_B] >> sh) & 32'hFF)
            + wc * longint'((tri_regs[REG_COLOR_C] >> sh) & 32'hFF);
        q = num / area;
        if (q > 255) q = 255;
        if (q < 0) q = 0;
        return q[7:0];
    endfunction

    function automatic t_shade shade_pixel(t_pixel p);
        t_shade r;
        longint signed ax, ay, bx, by, cx, cy, px, py, area, wa, wb, wc;
        ax = coord(tri_regs[REG_VERTEX_A_POS][15:0]);
        ay = coord(tri_regs[REG_VERTEX_A_POS][31:16]);
        bx = coord(tri_regs[REG_VERTEX_B_POS][15:0]);
        by = coord(tri_regs[REG_VERTEX_B_POS][31:16]);
        cx = coord(tri_regs[REG_VERTEX_C_POS][15:0]);
        cy = coord(tri_regs[REG_VERTEX_C_POS][31:16]);
        px = longint'(p.x);
        py = longint'(p.y);
        area = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
        wa = (bx - px) * (cy - py) - (cx - px) * (by - py);
        wb = (cx - px) * (ay - py) - (ax - px) * (cy - py);
        wc = (ax - px) * (by - py) - (bx - px) * (ay - py);
        // Clockwise winding flips every sign so the weights stay non-negative.
        if (area < 0) begin
            area = -area;
            wa = -wa;
            wb = -wb;
            wc = -wc;
        end
        r.x = p.x;
        r.y = p.y;
        r.covered = (area != 0) && (wa >= 0) && (wb >= 0) && (wc >= 0);
        r.color = 32'd0;
        if (r.covered)
            r.color = {ALPHA_FULL, blend(wa, wb, wc, area, 16),
                       blend(wa, wb, wc, area, 8), blend(wa, wb, wc, area, 0)};
        return r;
    endfunction

    // Driver: the payload changes only after a transfer or while valid is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                shades_due.push_back(shade_pixel('{i_pixel_x, i_pixel_y}));
            if (!i_valid || o_ready) begin
                if (pixels_to_send.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
                    t_pixel p;
                    p = pixels_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_pixel_x <= p.x;
                    i_pixel_y <= p.y;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (shades_due.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", o_out_x, o_out_y);
                    errors++;
                end else begin
                    t_shade e;
                    e = shades_due.pop_front();
                    if (o_covered !== e.covered) begin
                        $error("covered: expected %0d, got %0d", e.covered, o_covered);
                        errors++;
                    end
                    if (o_out_x !== e.x) begin
                        $error("out_x: expected %0d, got %0d", e.x, o_out_x);
                        errors++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y: expected %0d, got %0d", e.y, o_out_y);
                        errors++;
                    end
                    if (o_pixel_color !== e.color) begin
                        $error("pixel_color: expected %h, got %h", e.color, o_pixel_color);
                        errors++;
                    end
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)
                || (pixels_to_send.size() == 0 && shades_due.size() == 0 && !i_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 4000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        tri_regs[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] vertex(int x, int y);
        logic [15:0] hx, hy;
        hx = x[15:0];
        hy = y[15:0];
        return {hy, hx};
    endfunction

    task automatic load_triangle(logic [31:0] va, logic [31:0] vb, logic [31:0] vc,
                                 logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
        write_reg(REG_VERTEX_A_POS, va);
        write_reg(REG_VERTEX_B_POS, vb);
        write_reg(REG_VERTEX_C_POS, vc);
        write_reg(REG_COLOR_A, ca);
        write_reg(REG_COLOR_B, cb);
        write_reg(REG_COLOR_C, cc);
    endtask

    task automatic send_pixel(int x, int y);
        t_pixel p;
        p.x = x[11:0];
        p.y = y[11:0];
        pixels_to_send.push_back(p);
    endtask

    // The sender holds off until the pipeline has drained completely.
    task automatic drain();
        while (pixels_to_send.size() > 0 || i_valid || shades_due.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic int clamp_pixel(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    initial begin
        int x0, y0, span, lox, hix, loy, hiy;
        int xs[3];
        int ys[3];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        calm = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 6; i++) tri_regs[i] = 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers still at reset: a degenerate triangle that covers nothing.
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        drain();

        // Counterclockwise right triangle with pure red, green and blue corners.
        load_triangle(vertex(10, 10), vertex(40, 10), vertex(10, 40),
                      32'h12FF0000, 32'h0000FF00, 32'hA50000FF);
        send_pixel(10, 10); send_pixel(40, 10); send_pixel(10, 40);
        send_pixel(25, 10); send_pixel(10, 25); send_pixel(25, 25);
        send_pixel(15, 15); send_pixel(26, 26); send_pixel(0, 0);
        send_pixel(4095, 0); send_pixel(0, 4095);
        drain();

        // Same triangle wound clockwise.
        load_triangle(vertex(10, 10), vertex(10, 40), vertex(40, 10),
                      32'hFFFFFFFF, 32'h00808080, 32'h00010203);
        send_pixel(12, 12); send_pixel(40, 10); send_pixel(30, 30);
        drain();

        // Collinear vertices: pixels on the line still see zero area.
        load_triangle(vertex(0, 0), vertex(100, 100), vertex(50, 50),
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(50, 50); send_pixel(0, 0);
        drain();

        // Extreme coordinates spanning the whole signed range.
        load_triangle(vertex(-32768, -32768), vertex(32767, -32768),
                      vertex(-32768, 32767), 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00FFFFFF);
        send_pixel(0, 0); send_pixel(4095, 4095); send_pixel(4095, 0);
        send_pixel(2730, 1365);
        drain();

        for (int ph = 0; ph < 15; ph++) begin
            calm = (ph == 4);
            if ($urandom_range(3) == 0) begin
                for (int k = 0; k < 3; k++) begin
                    xs[k] = int'($signed(16'($urandom)));
                    ys[k] = int'($signed(16'($urandom)));
                end
            end else begin
                span = (ph % 3 == 0) ? 4200 : 300;
                x0 = $urandom_range(4095) - span / 4;
                y0 = $urandom_range(4095) - span / 4;
                for (int k = 0; k < 3; k++) begin
                    xs[k] = x0 + $urandom_range(span);
                    ys[k] = y0 + $urandom_range(span);
                end
            end
            load_triangle(vertex(xs[0], ys[0]), vertex(xs[1], ys[1]),
                          vertex(xs[2], ys[2]), $urandom, $urandom, $urandom);
            lox = clamp_pixel(xs[0] < xs[1] ? (xs[0] < xs[2] ? xs[0] : xs[2])
                                            : (xs[1] < xs[2] ? xs[1] : xs[2]));
            hix = clamp_pixel(xs[0] > xs[1] ? (xs[0] > xs[2] ? xs[0] : xs[2])
                                            : (xs[1] > xs[2] ? xs[1] : xs[2]));
            loy = clamp_pixel(ys[0] < ys[1] ? (ys[0] < ys[2] ? ys[0] : ys[2])
                                            : (ys[1] < ys[2] ? ys[1] : ys[2]));
            hiy = clamp_pixel(ys[0] > ys[1] ? (ys[0] > ys[2] ? ys[0] : ys[2])
                                            : (ys[1] > ys[2] ? ys[1] : ys[2]));
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(3) != 0)
                    send_pixel($urandom_range(hix, lox), $urandom_range(hiy, loy));
                else
                    send_pixel($urandom_range(4095), $urandom_range(4095));
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
